// ----- design/obrb_pkg.sv -----
// obrb_pkg: shared types and codes for the overwriting byte ring buffer
// no dependencies; used by the interfaces and every module of the block
package obrb_pkg;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_GET   = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERWRITE = 2'd1,
        STATUS_EMPTY     = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LOG2_W   = 4;
    localparam logic [LOG2_W-1:0] RESET_LOG2 = 4'd8;

endpackage

// ----- design/obrb_if.sv -----
// obrb_if: valid/ready channel interfaces for command, result and config words
// depends on obrb_pkg for the field widths
interface obrb_in_if;
    logic                             valid;
    logic                             ready;
    logic [obrb_pkg::KIND_W-1:0]      kind;
    logic [obrb_pkg::BYTE_W-1:0]      write_byte;

    modport source (output valid, output kind, output write_byte, input ready);
    modport sink   (input valid, input kind, input write_byte, output ready);
endinterface

interface obrb_out_if;
    logic                             valid;
    logic                             ready;
    logic [obrb_pkg::BYTE_W-1:0]      read_byte;
    logic [obrb_pkg::STATUS_W-1:0]    status;

    modport source (output valid, output read_byte, output status, input ready);
    modport sink   (input valid, input read_byte, input status, output ready);
endinterface

interface obrb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [obrb_pkg::LOG2_W-1:0]      ring_size_log2;

    modport source (output valid, output ring_size_log2, input ready);
    modport sink   (input valid, input ring_size_log2, output ready);
endinterface

// ----- design/obrb_store.sv -----
// obrb_store: byte store, one write port and one read port, registered read data
// depends on obrb_pkg for the byte width
module obrb_store #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [obrb_pkg::BYTE_W-1:0]   i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [obrb_pkg::BYTE_W-1:0]   o_rdata
);
    import obrb_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/obrb_ctrl.sv -----
// obrb_ctrl: head/tail indices, ring mask, command sequencing and result register
// depends on obrb_pkg and the channel interfaces; drives obrb_store
module obrb_ctrl #(
    parameter int unsigned MAX_DEPTH = 256,
    parameter int unsigned AW        = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    obrb_in_if.sink                       in_ch,
    obrb_out_if.source                    out_ch,
    obrb_cfg_if.sink                      cfg_ch,
    output logic                          o_mem_we,
    output logic [AW-1:0]                 o_mem_waddr,
    output logic [obrb_pkg::BYTE_W-1:0]   o_mem_wdata,
    output logic                          o_mem_re,
    output logic [AW-1:0]                 o_mem_raddr,
    input  logic [obrb_pkg::BYTE_W-1:0]   i_mem_rdata
);
    import obrb_pkg::*;

    localparam int unsigned LOG2_MAX   = $clog2(MAX_DEPTH + 1) - 1;
    localparam logic [4:0]  LOG2_MAX_W = 5'(LOG2_MAX);

    function automatic logic [AW-1:0] mask_from_log2(input logic [LOG2_W-1:0] k);
        logic [4:0]    k0;
        logic [4:0]    keff;
        logic [AW-1:0] m;
        k0   = (k == '0) ? 5'd1 : {1'b0, k};
        keff = (k0 > LOG2_MAX_W) ? LOG2_MAX_W : k0;
        for (int i = 0; i < AW; i++) begin
            m[i] = (5'(i) < keff);
        end
        return m;
    endfunction

    t_state              r_state, n_state;
    logic [AW-1:0]       r_wr_idx, n_wr_idx;
    logic [AW-1:0]       r_rd_idx, n_rd_idx;
    logic [AW-1:0]       r_mask, n_mask;
    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_rd_byte, n_rd_byte;
    logic [STATUS_W-1:0] r_status, n_status;

    logic                in_ready;
    logic                in_fire;
    logic                out_fire;
    logic                ring_full;
    logic                ring_empty;

    assign ring_full  = ((r_wr_idx - r_rd_idx) & r_mask) == r_mask;
    assign ring_empty = (r_wr_idx == r_rd_idx);
    assign in_ready   = (r_state == ST_IDLE) && (!r_out_valid || out_ch.ready);
    assign in_fire    = in_ch.valid && in_ready;
    assign out_fire   = r_out_valid && out_ch.ready;

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && !out_fire;
        n_rd_byte   = r_rd_byte;
        n_status    = r_status;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (in_ch.kind)
                        KIND_PUT: begin
                            o_mem_we    = 1'b1;
                            n_wr_idx    = (r_wr_idx + 1'b1) & r_mask;
                            n_rd_byte   = '0;
                            n_status    = STATUS_OK;
                            n_out_valid = 1'b1;
                            if (ring_full) begin
                                n_rd_idx = (r_rd_idx + 1'b1) & r_mask;
                                n_status = STATUS_OVERWRITE;
                            end
                        end
                        KIND_GET: begin
                            if (ring_empty) begin
                                n_rd_byte   = '0;
                                n_status    = STATUS_EMPTY;
                                n_out_valid = 1'b1;
                            end else begin
                                o_mem_re = 1'b1;
                                n_rd_idx = (r_rd_idx + 1'b1) & r_mask;
                                n_state  = ST_READ;
                            end
                        end
                        KIND_CLEAR: begin
                            n_wr_idx    = '0;
                            n_rd_idx    = '0;
                            n_rd_byte   = '0;
                            n_status    = STATUS_OK;
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_rd_byte   = '0;
                            n_status    = STATUS_OK;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_rd_byte   = i_mem_rdata;
                n_status    = STATUS_OK;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // config write restarts the ring
        if (cfg_ch.valid) begin
            n_mask   = mask_from_log2(cfg_ch.ring_size_log2);
            n_wr_idx = '0;
            n_rd_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_mask      <= mask_from_log2(RESET_LOG2);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_byte <= n_rd_byte;
        r_status  <= n_status;
    end

    assign in_ch.ready      = in_ready;
    assign cfg_ch.ready     = 1'b1;
    assign out_ch.valid     = r_out_valid;
    assign out_ch.read_byte = r_rd_byte;
    assign out_ch.status    = r_status;
    assign o_mem_waddr      = r_wr_idx;
    assign o_mem_wdata      = in_ch.write_byte;
    assign o_mem_raddr      = r_rd_idx;

`ifndef SYNTHESIS
    a_idx_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_wr_idx & ~r_mask) == '0) && ((r_rd_idx & ~r_mask) == '0))
        else $error("index outside ring mask");

    a_read_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("memory read did not produce a result word");

    a_empty_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == STATUS_EMPTY)) |-> (r_rd_byte == '0))
        else $error("empty get returned nonzero byte");

    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !in_ready)
        else $error("command accepted while memory read pending");
`endif

endmodule

// ----- design/overwriting_byte_ring_buffer.sv -----
// overwriting_byte_ring_buffer: top level, byte fifo in a ring with oldest-byte overwrite
// put, clear and empty get give their result word in the cycle after acceptance,
// a data get passes the store's registered read port and then the result register
// throughput: one put/clear per cycle if results drain; data gets block input in ST_READ
// reset: synchronous active-low i_rst_n zeroes both indices and sets ring size 256
// depends on obrb_pkg, obrb_if, obrb_store, obrb_ctrl
module overwriting_byte_ring_buffer #(
    parameter int unsigned MAX_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    obrb_in_if.sink       i_in,
    obrb_out_if.source    o_out,
    obrb_cfg_if.sink      i_cfg
);
    import obrb_pkg::*;

    localparam int unsigned AW = $clog2(MAX_DEPTH);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    obrb_ctrl #(
        .MAX_DEPTH (MAX_DEPTH),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (i_in),
        .out_ch      (o_out),
        .cfg_ch      (i_cfg),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    obrb_store #(
        .DEPTH (MAX_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ----- tb/sv/overwriting_byte_ring_buffer_tb.sv -----
// overwriting_byte_ring_buffer_tb: self-checking bench for the overwriting byte ring buffer,
// a directed table then random put/get/clear traffic over several ring sizes and stall mixes
// depends on obrb_pkg, obrb_if and the overwriting_byte_ring_buffer rtl
module overwriting_byte_ring_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import obrb_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 12;
    localparam int RING_DEPTH   = 256;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_DIRECTED   = 29;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        t_status           status;
    } t_ring_word;

    typedef struct packed {
        logic              is_cfg;
        logic [LOG2_W-1:0] cfg_val;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              typed;
        logic [BYTE_W-1:0] exp_byte;
        t_status           exp_status;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n;

    obrb_in_if  cmd_ch ();
    obrb_out_if res_ch ();
    obrb_cfg_if cfg_ch ();

    overwriting_byte_ring_buffer #(
        .MAX_DEPTH (RING_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // predicted ring state
    logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
    logic [7:0]        head_idx;
    logic [7:0]        tail_idx;
    logic [7:0]        size_mask;

    t_ring_word ring_expect_q [$];

    // expectation typed in the directed table, driven along with the word
    logic              typed_flag;
    logic [BYTE_W-1:0] typed_byte;
    t_status           typed_status;

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int n_cmds;
    int n_words;
    int n_overwrite;
    int n_empty;
    int n_cfg;
    int cycle_count;

    t_step directed [N_DIRECTED];

    function automatic logic [7:0] mask_for_log2(logic [LOG2_W-1:0] log2_val);
        int k;
        k = log2_val;
        if (k < 1) k = 1;
        while (k > 1 && (1 << k) > RING_DEPTH) k--;
        return 8'((1 << k) - 1);
    endfunction

    function automatic t_ring_word ring_apply(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data);
        t_ring_word w;
        w.read_byte = '0;
        w.status    = STATUS_OK;
        case (kind)
            KIND_PUT: begin
                if (((head_idx - tail_idx) & size_mask) == size_mask) begin
                    tail_idx = (tail_idx + 8'd1) & size_mask;
                    w.status = STATUS_OVERWRITE;
                end
                ring_bytes[head_idx] = data;
                head_idx = (head_idx + 8'd1) & size_mask;
            end
            KIND_GET: begin
                if (head_idx == tail_idx) begin
                    w.status = STATUS_EMPTY;
                end else begin
                    w.read_byte = ring_bytes[tail_idx];
                    tail_idx = (tail_idx + 8'd1) & size_mask;
                end
            end
            KIND_CLEAR: begin
                head_idx = '0;
                tail_idx = '0;
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_ring_word w;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                n_words++;
                if (ring_expect_q.size() == 0) begin
                    $display("%0t unexpected word: read_byte %0d status %0d", $time,
                             res_ch.read_byte, res_ch.status);
                    errors++;
                end else begin
                    w = ring_expect_q.pop_front();
                    if (res_ch.read_byte !== w.read_byte) begin
                        $display("%0t read_byte mismatch: expected %0d actual %0d", $time,
                                 w.read_byte, res_ch.read_byte);
                        errors++;
                    end
                    if (res_ch.status !== w.status) begin
                        $display("%0t status mismatch: expected %0d actual %0d", $time,
                                 w.status, res_ch.status);
                        errors++;
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                w = ring_apply(cmd_ch.kind, cmd_ch.write_byte);
                if (typed_flag) begin
                    w.read_byte = typed_byte;
                    w.status    = typed_status;
                end
                if (w.status == STATUS_OVERWRITE) n_overwrite++;
                if (w.status == STATUS_EMPTY) n_empty++;
                ring_expect_q.push_back(w);
                n_cmds++;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                size_mask = mask_for_log2(cfg_ch.ring_size_log2);
                head_idx  = '0;
                tail_idx  = '0;
                n_cfg++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles, %0d words outstanding", $time,
                     cycle_count, ring_expect_q.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic drive_cmd(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data, logic typed,
                             logic [BYTE_W-1:0] exp_byte, t_status exp_status);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.kind       <= kind;
        cmd_ch.write_byte <= data;
        typed_flag        <= typed;
        typed_byte        <= exp_byte;
        typed_status      <= exp_status;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_ring_size(logic [LOG2_W-1:0] log2_val);
        cmd_ch.valid <= 1'b0;
        while (ring_expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.ring_size_log2 <= log2_val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_segment(logic [LOG2_W-1:0] log2_val, int count, int put_pct,
                               int clear_pct);
        int r;
        logic [KIND_W-1:0] kind;
        write_ring_size(log2_val);
        repeat (count) begin
            r = $urandom_range(99);
            if (r < put_pct) kind = KIND_PUT;
            else if (r < 99 - clear_pct) kind = KIND_GET;
            else if (r < 99) kind = KIND_CLEAR;
            else kind = KIND_UNUSED;
            drive_cmd(kind, 8'($urandom), 1'b0, '0, STATUS_OK);
        end
    endtask

    initial begin
        int send_pct [3];
        int recv_pct [3];
        send_pct = '{7, 79, 0};
        recv_pct = '{79, 7, 0};

        i_rst_n               = 1'b0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.kind           = KIND_PUT;
        cmd_ch.write_byte     = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.ring_size_log2 = RESET_LOG2;
        res_ch.ready          = 1'b0;
        typed_flag            = 1'b0;
        typed_byte            = '0;
        typed_status          = STATUS_OK;
        errors                = 0;
        n_cmds                = 0;
        n_words               = 0;
        n_overwrite           = 0;
        n_empty               = 0;
        n_cfg                 = 0;
        cycle_count           = 0;
        send_idle_pct         = send_pct[0];
        recv_idle_pct         = recv_pct[0];
        foreach (ring_bytes[i]) ring_bytes[i] = '0;
        head_idx  = '0;
        tail_idx  = '0;
        size_mask = mask_for_log2(RESET_LOG2);

        directed = '{
            '{1'b0, 4'd0,  KIND_GET,    8'h00, 1'b1, 8'h00, STATUS_EMPTY},
            '{1'b0, 4'd0,  KIND_UNUSED, 8'hff, 1'b1, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_PUT,    8'h00, 1'b1, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_PUT,    8'hff, 1'b1, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_PUT,    8'h5a, 1'b1, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_GET,    8'hff, 1'b0, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_GET,    8'h00, 1'b0, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_CLEAR,  8'hff, 1'b1, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_GET,    8'h00, 1'b1, 8'h00, STATUS_EMPTY},
            '{1'b1, 4'd1,  KIND_PUT,    8'h00, 1'b0, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_PUT,    8'ha5, 1'b1, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_PUT,    8'h3c, 1'b1, 8'h00, STATUS_OVERWRITE},
            '{1'b0, 4'd0,  KIND_GET,    8'h00, 1'b0, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_GET,    8'h00, 1'b1, 8'h00, STATUS_EMPTY},
            '{1'b1, 4'd0,  KIND_PUT,    8'h00, 1'b0, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_PUT,    8'h81, 1'b1, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_PUT,    8'h7e, 1'b1, 8'h00, STATUS_OVERWRITE},
            '{1'b1, 4'd15, KIND_PUT,    8'h00, 1'b0, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_GET,    8'h00, 1'b1, 8'h00, STATUS_EMPTY},
            '{1'b0, 4'd0,  KIND_PUT,    8'h01, 1'b1, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_GET,    8'h00, 1'b0, 8'h00, STATUS_OK},
            '{1'b1, 4'd2,  KIND_PUT,    8'h00, 1'b0, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_PUT,    8'h10, 1'b1, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_PUT,    8'h20, 1'b1, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_PUT,    8'h30, 1'b1, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_PUT,    8'h40, 1'b1, 8'h00, STATUS_OVERWRITE},
            '{1'b0, 4'd0,  KIND_GET,    8'h00, 1'b0, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_GET,    8'h00, 1'b0, 8'h00, STATUS_OK},
            '{1'b0, 4'd0,  KIND_GET,    8'h00, 1'b0, 8'h00, STATUS_OK}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                write_ring_size(directed[i].cfg_val);
            end else begin
                drive_cmd(directed[i].kind, directed[i].data, directed[i].typed,
                          directed[i].exp_byte, directed[i].exp_status);
            end
        end

        for (int m = 0; m < 3; m++) begin
            send_idle_pct = send_pct[m];
            recv_idle_pct = recv_pct[m];
            run_segment(4'd1, 30, 50, 3);
            run_segment(4'd2, 30, 60, 3);
            run_segment(4'($urandom_range(3, 7)), 40, $urandom_range(30, 80), 3);
            run_segment(4'd0, 20, 55, 3);
            run_segment(4'($urandom_range(9, 15)), 30, 60, 3);
        end
        // fill the full-size ring until the oldest byte gets dropped
        run_segment(4'd8, 320, 95, 0);

        cmd_ch.valid <= 1'b0;
        while (ring_expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d commands and %0d result words over %0d ring size writes",
                 n_cmds, n_words, n_cfg);
        $display("including %0d overwrites of the oldest byte and %0d gets on an empty ring",
                 n_overwrite, n_empty);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
